// ===== rtl/gsf_pkg.sv =====
// gsf_pkg: shared types, register codes and reset values of the gradient sharpening filter.
// No dependencies; every rtl file refers to it by scoped names.
`timescale 1ns / 1ps

package gsf_pkg;

    // Field and register widths fixed by the block's definition
    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned WIDTH_REG_W = 12;
    localparam int unsigned THRESH_W    = 9;
    localparam int unsigned BOOST_W     = 8;
    localparam int unsigned CFG_DATA_W  = 12;
    localparam int unsigned CFG_IDX_W   = 2;

    // Default geometry limits
    localparam int unsigned MAX_WIDTH_DEF  = 2048;
    localparam int unsigned MAX_HEIGHT_DEF = 4096;
    localparam int unsigned MIN_WIDTH      = 2;

    // Depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // Register reset values
    localparam logic [WIDTH_REG_W-1:0] IMAGE_WIDTH_RST = 12'd640;
    localparam logic [THRESH_W-1:0]    THRESHOLD_RST   = 9'd80;
    localparam logic [BOOST_W-1:0]     BOOST_RST       = 8'd100;

    localparam logic [CHAN_W-1:0] PIX_MAX = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH = 2'd0,
        CFG_THRESHOLD   = 2'd1,
        CFG_BOOST       = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_rgb;

    // The three pixels one gradient needs
    typedef struct packed {
        t_rgb center;
        t_rgb right;
        t_rgb below;
    } t_trio;

    typedef struct packed {
        logic [THRESH_W-1:0] threshold;
        logic [BOOST_W-1:0]  boost;
    } t_sharp_cfg;

endpackage

// ===== rtl/gradient_sharpen_filter_top.sv =====
// gradient_sharpen_filter_top: top level of the streaming gradient sharpening filter.
// Depends on gsf_pkg, gsf_front, gsf_queue and gsf_back.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                Payload
//  -------   ---------  -----------------------  ---------------------------------------
//  cfg       in         i_cfg_we                 i_cfg_index, i_cfg_data
//  pixel in  in         i_in_valid / o_in_stall  i_red, i_green, i_blue, i_frame_start
//  pixel out out        o_out_valid / i_out_stall o_out_red/green/blue, o_out_column/row
//
//  One pixel beat per clock while o_in_stall is low; a result beat leaves after the
//  pixel that completes its neighborhood, via row store read, queue, output register.
//  The row store is one read-first port, read and written once per beat.
//  Reset is synchronous, active low; the row store has no clearing pass and holds
//  nothing valid until written. A stalled output fills the four-entry queue and
//  then stalls the input; pixels that carry no result never wait on the queue.

module gradient_sharpen_filter_top #(
    parameter int unsigned MAX_WIDTH  = gsf_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = gsf_pkg::MAX_HEIGHT_DEF,
    localparam int unsigned CW = $clog2(MAX_WIDTH),
    localparam int unsigned RW = $clog2(MAX_HEIGHT)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gsf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gsf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [gsf_pkg::CHAN_W-1:0]      i_red,
    input  logic [gsf_pkg::CHAN_W-1:0]      i_green,
    input  logic [gsf_pkg::CHAN_W-1:0]      i_blue,
    input  logic                            i_frame_start,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [gsf_pkg::CHAN_W-1:0]      o_out_red,
    output logic [gsf_pkg::CHAN_W-1:0]      o_out_green,
    output logic [gsf_pkg::CHAN_W-1:0]      o_out_blue,
    output logic [CW-1:0]                   o_out_column,
    output logic [RW-1:0]                   o_out_row
);

    localparam int unsigned QW = $bits(gsf_pkg::t_trio) + CW + RW;

    // configuration registers
    logic [gsf_pkg::WIDTH_REG_W-1:0] r_image_width;
    gsf_pkg::t_sharp_cfg             r_sharp_cfg;

    gsf_pkg::t_rgb  in_px;
    gsf_pkg::t_rgb  out_px;
    gsf_pkg::t_trio f_trio;
    gsf_pkg::t_trio q_trio;
    logic [CW-1:0]  f_col, q_col;
    logic [RW-1:0]  f_row, q_row;
    logic [QW-1:0]  q_wdata, q_rdata;
    logic           q_push, q_pop, q_full, q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width         <= gsf_pkg::IMAGE_WIDTH_RST;
            r_sharp_cfg.threshold <= gsf_pkg::THRESHOLD_RST;
            r_sharp_cfg.boost     <= gsf_pkg::BOOST_RST;
        end else if (i_cfg_we) begin
            unique case (gsf_pkg::t_cfg_idx'(i_cfg_index))
                gsf_pkg::CFG_IMAGE_WIDTH: r_image_width <= i_cfg_data;
                gsf_pkg::CFG_THRESHOLD:
                    r_sharp_cfg.threshold <= i_cfg_data[gsf_pkg::THRESH_W-1:0];
                gsf_pkg::CFG_BOOST:
                    r_sharp_cfg.boost <= i_cfg_data[gsf_pkg::BOOST_W-1:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    assign in_px.red   = i_red;
    assign in_px.green = i_green;
    assign in_px.blue  = i_blue;

    gsf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_image_width (r_image_width),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_px          (in_px),
        .i_frame_start (i_frame_start),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_trio        (f_trio),
        .o_col         (f_col),
        .o_row         (f_row)
    );

    assign q_wdata = {f_trio, f_col, f_row};

    gsf_queue #(
        .WIDTH (QW),
        .DEPTH (gsf_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign {q_trio, q_col, q_row} = q_rdata;

    gsf_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_sharp_cfg),
        .i_q_empty   (q_empty),
        .i_trio      (q_trio),
        .i_col       (q_col),
        .i_row       (q_row),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_px        (out_px),
        .o_col       (o_out_column),
        .o_row       (o_out_row)
    );

    assign o_out_red   = out_px.red;
    assign o_out_green = out_px.green;
    assign o_out_blue  = out_px.blue;

endmodule

// ===== rtl/gsf_front.sv =====
// gsf_front: position tracking, row store and neighbor gathering of the sharpening filter.
// Depends on gsf_pkg; pushes one entry per pixel that has a result into the queue.
`timescale 1ns / 1ps

module gsf_front #(
    parameter int unsigned MAX_WIDTH  = gsf_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = gsf_pkg::MAX_HEIGHT_DEF,
    localparam int unsigned CW = $clog2(MAX_WIDTH),
    localparam int unsigned RW = $clog2(MAX_HEIGHT)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [gsf_pkg::WIDTH_REG_W-1:0]     i_image_width,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  gsf_pkg::t_rgb                       i_px,
    input  logic                                i_frame_start,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output gsf_pkg::t_trio                      o_trio,
    output logic [CW-1:0]                       o_col,
    output logic [RW-1:0]                       o_row
);

    localparam int unsigned EW = (CW + 1 > gsf_pkg::WIDTH_REG_W) ? CW + 1 : gsf_pkg::WIDTH_REG_W;
    localparam logic [RW-1:0] ROW_LAST = RW'(MAX_HEIGHT - 1);

    // row store of the previous line, undefined until written
    gsf_pkg::t_rgb r_mem [MAX_WIDTH];

    logic [CW-1:0]  r_col, n_col;
    logic [RW-1:0]  r_row, n_row;
    logic [EW-1:0]  w_eff;
    logic [CW-1:0]  c_in;
    logic [RW-1:0]  r_in;
    logic [EW-1:0]  col_next;
    logic           in_acc;
    logic           b_retire;

    logic           r_b_valid;
    logic           r_b_emit;
    logic [CW-1:0]  r_b_col;
    logic [RW-1:0]  r_b_row;
    gsf_pkg::t_rgb  r_b_px;
    gsf_pkg::t_rgb  r_above;
    gsf_pkg::t_rgb  r_held_above;
    gsf_pkg::t_rgb  r_held_left;

    function automatic logic [RW-1:0] row_step(input logic [RW-1:0] row);
        row_step = (row < ROW_LAST) ? row + RW'(1) : row;
    endfunction

    always_comb begin
        if (i_image_width < gsf_pkg::WIDTH_REG_W'(gsf_pkg::MIN_WIDTH)) begin
            w_eff = EW'(gsf_pkg::MIN_WIDTH);
        end else if (EW'(i_image_width) > EW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = EW'(i_image_width);
        end
    end

    // position of the incoming pixel, then the position after it
    always_comb begin
        priority if (i_frame_start) begin
            c_in = '0;
            r_in = '0;
        end else if (EW'(r_col) >= w_eff) begin
            c_in = '0;
            r_in = row_step(r_row);
        end else begin
            c_in = r_col;
            r_in = r_row;
        end
        col_next = EW'(c_in) + EW'(1);
        if (col_next >= w_eff) begin
            n_col = '0;
            n_row = row_step(r_in);
        end else begin
            n_col = col_next[CW-1:0];
            n_row = r_in;
        end
    end

    assign o_in_stall = r_b_valid && r_b_emit && i_q_full;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign b_retire   = r_b_valid && !(r_b_emit && i_q_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_b_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (in_acc) begin
                r_b_valid <= 1'b1;
            end else if (b_retire) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    // read-first: the old entry comes out as the new pixel goes in
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_above    <= r_mem[c_in];
            r_mem[c_in] <= i_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_emit <= (c_in != '0) && (r_in != '0);
            r_b_col  <= c_in - CW'(1);
            r_b_row  <= r_in - RW'(1);
            r_b_px   <= i_px;
        end
        if (b_retire) begin
            r_held_above <= r_above;
            r_held_left  <= r_b_px;
        end
    end

    assign o_q_push      = r_b_valid && r_b_emit && !i_q_full;
    assign o_trio.center = r_held_above;
    assign o_trio.right  = r_above;
    assign o_trio.below  = r_held_left;
    assign o_col         = r_b_col;
    assign o_row         = r_b_row;

    a_row_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_row <= ROW_LAST)
        else $error("row counter past its saturation value");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> r_b_valid)
        else $error("pending pixel lost while input stalled");
    a_emit_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (c_in != '0) && (r_in != '0) |=> r_b_valid && r_b_emit)
        else $error("pixel with neighbors not marked for a result");

endmodule

// ===== rtl/gsf_queue.sv =====
// gsf_queue: small synchronous FIFO between the front and back of the sharpening filter.
// Depends on gsf_pkg only for its default depth.
`timescale 1ns / 1ps

module gsf_queue #(
    parameter int unsigned WIDTH = 96,
    parameter int unsigned DEPTH = gsf_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [NW-1:0]    r_count;

    function automatic logic [PW-1:0] ptr_step(input logic [PW-1:0] p);
        ptr_step = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_data[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_step(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_step(r_rptr);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + NW'(1);
                2'b01:   r_count <= r_count - NW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wptr] <= i_wdata;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n) i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pop |-> !o_empty)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== rtl/gsf_back.sv =====
// gsf_back: gradient, threshold and boost per channel, with the registered output beat.
// Depends on gsf_pkg; takes entries from gsf_queue.
`timescale 1ns / 1ps

module gsf_back #(
    parameter int unsigned MAX_WIDTH  = gsf_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = gsf_pkg::MAX_HEIGHT_DEF,
    localparam int unsigned CW = $clog2(MAX_WIDTH),
    localparam int unsigned RW = $clog2(MAX_HEIGHT)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gsf_pkg::t_sharp_cfg             i_cfg,
    input  logic                            i_q_empty,
    input  gsf_pkg::t_trio                  i_trio,
    input  logic [CW-1:0]                   i_col,
    input  logic [RW-1:0]                   i_row,
    output logic                            o_q_pop,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output gsf_pkg::t_rgb                   o_px,
    output logic [CW-1:0]                   o_col,
    output logic [RW-1:0]                   o_row
);

    logic          r_out_valid;
    gsf_pkg::t_rgb r_px;
    gsf_pkg::t_rgb n_px;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    function automatic logic [gsf_pkg::CHAN_W-1:0] sharpen(
        input logic [gsf_pkg::CHAN_W-1:0] c,
        input logic [gsf_pkg::CHAN_W-1:0] r,
        input logic [gsf_pkg::CHAN_W-1:0] d,
        input gsf_pkg::t_sharp_cfg        cfg
    );
        logic [gsf_pkg::CHAN_W-1:0] dr;
        logic [gsf_pkg::CHAN_W-1:0] dd;
        logic [gsf_pkg::CHAN_W:0]   g;
        logic [gsf_pkg::CHAN_W+1:0] v;
        dr = (c > r) ? c - r : r - c;
        dd = (c > d) ? c - d : d - c;
        g  = {1'b0, dr} + {1'b0, dd};
        v  = {1'b0, g} + (gsf_pkg::CHAN_W + 2)'(cfg.boost);
        if (g > cfg.threshold) begin
            sharpen = (v > (gsf_pkg::CHAN_W + 2)'(gsf_pkg::PIX_MAX)) ?
                      gsf_pkg::PIX_MAX : v[gsf_pkg::CHAN_W-1:0];
        end else begin
            sharpen = c;
        end
    endfunction

    always_comb begin
        n_px.red   = sharpen(i_trio.center.red,   i_trio.right.red,   i_trio.below.red,   i_cfg);
        n_px.green = sharpen(i_trio.center.green, i_trio.right.green, i_trio.below.green, i_cfg);
        n_px.blue  = sharpen(i_trio.center.blue,  i_trio.right.blue,  i_trio.below.blue,  i_cfg);
    end

    assign o_q_pop = !i_q_empty && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_px  <= n_px;
            r_col <= i_col;
            r_row <= i_row;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_px        = r_px;
    assign o_col       = r_col;
    assign o_row       = r_row;

endmodule

// ===== tb/gradient_sharpen_filter_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for gradient_sharpen_filter_top: random RGB frames in, sharpened
// pixels out, compared beat by beat with an in-bench sharpening tracker.
// Depends on gsf_pkg and the RTL of gradient_sharpen_filter_top only.

module gradient_sharpen_filter_top_tb;
    import gsf_pkg::*;

    localparam int MAX_W        = MAX_WIDTH_DEF;
    localparam int MAX_H        = MAX_HEIGHT_DEF;
    localparam int COL_W        = $clog2(MAX_W);
    localparam int ROW_W        = $clog2(MAX_H);
    localparam int QUIET_CYCLES = 8;        // pipeline is three deep; leave margin
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_BEATS = 1700;
    localparam int HOLD_CYCLES  = 400;      // long output hold-off, fills the queue

    // One output pixel as the block reports it
    typedef struct packed {
        t_rgb              pix;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
    } t_sharp_pixel;

    // Tracks the filter state (row store, position, neighbors) and the sharpened
    // pixels still owed by the block.
    class sharpen_tracker;
        logic [WIDTH_REG_W-1:0] width_reg;
        logic [THRESH_W-1:0]    threshold;
        logic [BOOST_W-1:0]     boost;
        t_rgb                   row_store [MAX_W];
        bit                     written [MAX_W];
        int                     column_count;
        int                     row_count;
        t_rgb                   held_above;
        t_rgb                   held_left;
        t_sharp_pixel           pending_pixels [$];
        int                     pixels_in;
        int                     results_checked;
        int                     failures;

        function new();
            width_reg    = IMAGE_WIDTH_RST;
            threshold    = THRESHOLD_RST;
            boost        = BOOST_RST;
            column_count = 0;
            row_count    = 0;
            held_above   = '0;
            held_left    = '0;
            foreach (row_store[i]) begin
                row_store[i] = '0;
                written[i]   = 1'b0;
            end
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_IMAGE_WIDTH: width_reg = data[WIDTH_REG_W-1:0];
                CFG_THRESHOLD:   threshold = data[THRESH_W-1:0];
                CFG_BOOST:       boost     = data[BOOST_W-1:0];
                default: ;
            endcase
        endfunction

        function int active_width();
            int w;
            w = int'(width_reg);
            if (w < MIN_WIDTH) w = MIN_WIDTH;
            if (w > MAX_W) w = MAX_W;
            return w;
        endfunction

        function void step_row();
            column_count = 0;
            if (row_count < MAX_H - 1) row_count++;
        endfunction

        // True when a pixel without frame_start would land on a row-store entry
        // that no earlier row has filled (width raised within a frame).
        function bit needs_restart();
            int col;
            int row;
            col = column_count;
            row = row_count;
            if (col >= active_width()) begin
                col = 0;
                row++;
            end
            return (row >= 1) && !written[col];
        endfunction

        function logic [7:0] sharpen_channel(logic [7:0] c, logic [7:0] right,
                                             logic [7:0] below);
            int g;
            int v;
            g = ((c > right) ? c - right : right - c) + ((c > below) ? c - below : below - c);
            if (g > int'(threshold)) begin
                v = g + int'(boost);
                return (v > 255) ? PIX_MAX : 8'(v);
            end
            return c;
        endfunction

        function void accept_pixel(t_rgb px, bit fs);
            int           w;
            t_rgb         above;
            t_sharp_pixel res;
            w = active_width();
            pixels_in++;
            if (fs) begin
                column_count = 0;
                row_count    = 0;
            end else if (column_count >= w) begin
                step_row();
            end
            above = row_store[column_count];
            // Result for the pixel up and to the left of the one arriving now
            if (column_count >= 1 && row_count >= 1) begin
                res.pix.red   = sharpen_channel(held_above.red, above.red, held_left.red);
                res.pix.green = sharpen_channel(held_above.green, above.green,
                                                held_left.green);
                res.pix.blue  = sharpen_channel(held_above.blue, above.blue, held_left.blue);
                res.column    = COL_W'(column_count - 1);
                res.row       = ROW_W'(row_count - 1);
                pending_pixels.push_back(res);
            end
            row_store[column_count] = px;
            written[column_count]   = 1'b1;
            held_above = above;
            held_left  = px;
            column_count++;
            if (column_count >= w) step_row();
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_pixel(t_sharp_pixel got);
            t_sharp_pixel want;
            if (pending_pixels.size() == 0) begin
                $error("unexpected output beat at column %0d row %0d", got.column, got.row);
                failures++;
                return;
            end
            want = pending_pixels.pop_front();
            results_checked++;
            compare_field("out_red",    want.pix.red,   got.pix.red);
            compare_field("out_green",  want.pix.green, got.pix.green);
            compare_field("out_blue",   want.pix.blue,  got.pix.blue);
            compare_field("out_column", want.column,    got.column);
            compare_field("out_row",    want.row,       got.row);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals: every input starts at a known value
    // ------------------------------------------------------------------
    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   i_in_valid    = 1'b0;
    logic                   o_in_stall;
    logic [CHAN_W-1:0]      i_red         = '0;
    logic [CHAN_W-1:0]      i_green       = '0;
    logic [CHAN_W-1:0]      i_blue        = '0;
    logic                   i_frame_start = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall   = 1'b0;
    logic [CHAN_W-1:0]      o_out_red;
    logic [CHAN_W-1:0]      o_out_green;
    logic [CHAN_W-1:0]      o_out_blue;
    logic [COL_W-1:0]       o_out_column;
    logic [ROW_W-1:0]       o_out_row;

    sharpen_tracker tracker;

    int send_idle_pct = 29;     // chance per cycle that the pixel source idles
    int recv_idle_pct = 85;     // chance per cycle that the sink stalls
    int hold_cycles   = 0;      // pending long hold-off on the output side
    int cycles        = 0;
    int phases        = 0;
    int config_writes = 0;

    gradient_sharpen_filter_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_frame_start (i_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .o_out_column  (o_out_column),
        .o_out_row     (o_out_row)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost result ends here
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("gradient_sharpen_filter_top regression: fail");
        $finish;
    end

    // Output side: take a beat at every edge with valid high and stall low, then
    // pick the stall for the next cycle. A requested hold-off overrides the dice.
    initial begin
        t_sharp_pixel got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.pix.red   = o_out_red;
                got.pix.green = o_out_green;
                got.pix.blue  = o_out_blue;
                got.column    = o_out_column;
                got.row       = o_out_row;
                tracker.check_pixel(got);
            end
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                hold_cycles--;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offers one pixel beat after a random gap and returns at the edge that takes it.
    // Valid stays high between back-to-back beats, so it is assigned once per step.
    task automatic send_pixel(t_rgb px, bit fs);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_red         <= px.red;
        i_green       <= px.green;
        i_blue        <= px.blue;
        i_frame_start <= fs;
        do @(posedge i_clk); while (o_in_stall);
        tracker.accept_pixel(px, fs);
    endtask

    // Source goes quiet until every owed pixel is out, then lets pixels that
    // carry no result clear the pipeline before any register changes.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        tracker.set_reg(idx, data);
        config_writes++;
    endtask

    function automatic t_rgb rgb(int r, int g, int b);
        t_rgb p;
        p.red   = 8'(r);
        p.green = 8'(g);
        p.blue  = 8'(b);
        return p;
    endfunction

    // Mix of rails, near-neighbor values (gradients around the threshold) and noise
    function automatic logic [7:0] random_channel(logic [7:0] c);
        int v;
        case ($urandom_range(0, 5))
            0: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            1, 2: begin
                v = int'(c) + int'($urandom_range(0, 60)) - 30;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return 8'(v);
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Streams a run of pixels. The first one opens a frame when asked; noise_pct
    // drops stray frame starts into the middle. A frame start is forced whenever
    // the row above would come from a never-filled row-store entry.
    task automatic send_frame(int pixels, bit restart, int noise_pct);
        t_rgb prev;
        t_rgb px;
        bit   fs;
        prev = rgb($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        for (int i = 0; i < pixels; i++) begin
            px.red   = random_channel(prev.red);
            px.green = random_channel(prev.green);
            px.blue  = random_channel(prev.blue);
            fs = (i == 0 && restart) || ($urandom_range(0, 99) < noise_pct);
            send_pixel(px, fs || tracker.needs_restart());
            prev = px;
        end
    endtask

    // One random phase: new settings while idle, then a frame of a few rows.
    // Now and then the frame simply continues across the settings change.
    task automatic random_phase();
        int w;
        int rows;
        int pick;
        drain();
        pick = $urandom_range(0, 19);
        if (pick == 0) w = $urandom_range(0, 1);            // clamps up to two
        else if (pick == 1) w = MIN_WIDTH;
        else if (pick == 2) w = $urandom_range(100, 300);
        else w = $urandom_range(3, 24);
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        if ($urandom_range(0, 1) != 0) begin
            pick = $urandom_range(0, 5);
            write_reg(CFG_THRESHOLD, CFG_DATA_W'((pick == 0) ? 0 : (pick == 1) ? 510 :
                      (pick == 2) ? $urandom_range(0, 40) : $urandom_range(0, 510)));
        end
        if ($urandom_range(0, 1) != 0) begin
            pick = $urandom_range(0, 5);
            write_reg(CFG_BOOST, CFG_DATA_W'((pick == 0) ? 0 : (pick == 1) ? 255 :
                      $urandom_range(0, 255)));
        end
        w = tracker.active_width();
        rows = (w >= 100) ? 2 : $urandom_range(2, 6);
        send_frame(w * rows + $urandom_range(0, w - 1), $urandom_range(0, 3) != 0, 2);
        phases++;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        tracker = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: counters start at zero with no frame start, reset threshold and
        // boost, rail values (0 against 255 saturates the boost).
        write_reg(CFG_IMAGE_WIDTH, 12'd3);
        for (int i = 0; i < 9; i++)
            send_pixel(rgb(i[0] ? 255 : 0, (i >= 3) ? 255 : 0, i * 30), 1'b0);
        drain();

        // Width below range clamps to two; top threshold never sharpens, top boost
        write_reg(CFG_IMAGE_WIDTH, 12'd0);
        write_reg(CFG_THRESHOLD, 12'd510);
        write_reg(CFG_BOOST, 12'd255);
        for (int i = 0; i < 6; i++)
            send_pixel(rgb(i[0] ? 255 : 0, i[1] ? 0 : 255, 255), i == 0);
        drain();

        // Zero threshold, zero boost: a gradient of one already sharpens
        write_reg(CFG_IMAGE_WIDTH, 12'd4);
        write_reg(CFG_THRESHOLD, 12'd0);
        write_reg(CFG_BOOST, 12'd0);
        for (int i = 0; i < 6; i++)
            send_pixel(rgb(100 + i % 2, 100, 200 - i), i == 0);
        drain();

        // Width lowered mid-row: the next pixel wraps to a new row
        write_reg(CFG_IMAGE_WIDTH, 12'd2);
        for (int i = 0; i < 3; i++)
            send_pixel(rgb(7 * i, 255 - 40 * i, 90), 1'b0);
        phases += 4;

        // Random part in three idling regimes
        for (int regime = 0; regime < 3; regime++) begin
            case (regime)
                0: begin send_idle_pct = 29; recv_idle_pct = 85; end
                1: begin send_idle_pct = 85; recv_idle_pct = 29; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (regime == 0) begin
                // Source runs flat out into a long output hold-off: the queue fills
                // and the input stall must back up cleanly.
                drain();
                send_idle_pct = 0;
                write_reg(CFG_IMAGE_WIDTH, 12'd8);
                hold_cycles = HOLD_CYCLES;
                send_frame(96, 1'b1, 0);
                send_idle_pct = 29;
                phases++;
            end
            begin
                int start;
                start = tracker.pixels_in;
                while (tracker.pixels_in - start < RANDOM_BEATS / 3) random_phase();
            end
        end

        drain();
        repeat (QUIET_CYCLES) @(posedge i_clk);
        if (tracker.pending_pixels.size() != 0) begin
            $error("%0d output beats never arrived", tracker.pending_pixels.size());
            tracker.failures++;
        end
        $display("Covered %0d pixel beats over %0d phases, %0d register writes, %0d results",
                 tracker.pixels_in, phases, config_writes, tracker.results_checked);
        $display("incl. clamped widths, mid-row width drop, long output hold-off, rail values");
        if (tracker.failures == 0)
            $display("gradient_sharpen_filter_top regression: pass");
        else
            $display("gradient_sharpen_filter_top regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gsf_pkg.sv
rtl/gsf_front.sv
rtl/gsf_queue.sv
rtl/gsf_back.sv
rtl/gradient_sharpen_filter_top.sv
tb/gradient_sharpen_filter_top_tb.sv
